[hdl/sfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

    // Field and register widths
    localparam int FRAME_W      = 8;
    localparam int COUNT_W      = 9;
    localparam int TICK_REG_W   = 16;
    localparam int SPEED_W      = 8;
    localparam int MODE_W       = 2;
    localparam int OPCODE_W     = 3;
    localparam int STATE_W      = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int SUM_W        = TICK_REG_W + 1;
    localparam int IN_TDATA_W   = 8;
    localparam int IN_TUSER_W   = 3;
    localparam int OUT_TDATA_W  = 16;

    // Parameter defaults
    localparam int DEF_MAX_FRAMES = 256;
    localparam int DEF_TICK_WIDTH = 16;

    // Largest frame count the 8-bit frame index can address
    localparam int FRAME_LIMIT = 256;

    // Command codes
    localparam logic [OPCODE_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PLAY      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP      = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_PAUSE     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RESUME    = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SET_FRAME = 3'd5;

    // Run states
    localparam logic [STATE_W-1:0] ST_STOPPED = 2'd0;
    localparam logic [STATE_W-1:0] ST_PLAYING = 2'd1;
    localparam logic [STATE_W-1:0] ST_PAUSED  = 2'd2;

    // End behaviours; the unused code behaves as repeat
    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TOTAL    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_STEP = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_STEP     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MODE       = 2'd3;

    // Effective configuration seen by the sequencer
    typedef struct packed {
        logic [COUNT_W-1:0]    num_frames;
        logic [TICK_REG_W-1:0] ticks;
        logic [SPEED_W-1:0]    speed;
        logic [MODE_W-1:0]     end_mode;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic                 rejected;
        logic                 anim_done;
        logic                 loop_complete;
        logic                 frame_changed;
        logic [STATE_W-1:0]   run_state;
        logic [FRAME_W-1:0]   shown_frame;
    } t_result;

endpackage

`default_nettype wire

[hdl/sfa_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfa_cfg #(
    parameter int MAX_FRAMES = sfa_pkg::DEF_MAX_FRAMES,
    parameter int TICK_WIDTH = sfa_pkg::DEF_TICK_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [sfa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output sfa_pkg::t_cfg                           o_cfg
);

    // Frame count ceiling and usable tick bits, settled at elaboration
    localparam int LIMIT_INT = (MAX_FRAMES < sfa_pkg::FRAME_LIMIT) ?
                               MAX_FRAMES : sfa_pkg::FRAME_LIMIT;
    localparam logic [sfa_pkg::COUNT_W-1:0] LIMIT = sfa_pkg::COUNT_W'(LIMIT_INT);
    localparam int TICK_BITS = (TICK_WIDTH < sfa_pkg::TICK_REG_W) ?
                               TICK_WIDTH : sfa_pkg::TICK_REG_W;
    localparam logic [sfa_pkg::TICK_REG_W-1:0] TICK_MASK =
        sfa_pkg::TICK_REG_W'((64'd1 << TICK_BITS) - 64'd1);

    logic [sfa_pkg::COUNT_W-1:0]    r_frame_total;
    logic [sfa_pkg::TICK_REG_W-1:0] r_ticks_per_step;
    logic [sfa_pkg::SPEED_W-1:0]    r_speed_step;
    logic [sfa_pkg::MODE_W-1:0]     r_end_mode;

    logic [sfa_pkg::TICK_REG_W-1:0] masked_ticks;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_total    <= sfa_pkg::COUNT_W'(1);
            r_ticks_per_step <= sfa_pkg::TICK_REG_W'(1);
            r_speed_step     <= sfa_pkg::SPEED_W'(1);
            r_end_mode       <= sfa_pkg::MODE_ONCE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sfa_pkg::REG_FRAME_TOTAL: begin
                    r_frame_total <= i_cfg_data[sfa_pkg::COUNT_W-1:0];
                end
                sfa_pkg::REG_TICKS_PER_STEP: begin
                    r_ticks_per_step <= i_cfg_data;
                end
                sfa_pkg::REG_SPEED_STEP: begin
                    r_speed_step <= i_cfg_data[sfa_pkg::SPEED_W-1:0];
                end
                sfa_pkg::REG_END_MODE: begin
                    r_end_mode <= i_cfg_data[sfa_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective values: a zero count or zero tick period acts as one, and the
    // count is held to MAX_FRAMES and to what the frame index can reach.
    assign masked_ticks = r_ticks_per_step & TICK_MASK;

    always_comb begin
        o_cfg.num_frames = (r_frame_total == '0) ? sfa_pkg::COUNT_W'(1) : r_frame_total;
        if (o_cfg.num_frames > LIMIT) begin
            o_cfg.num_frames = LIMIT;
        end
        o_cfg.ticks    = (masked_ticks == '0) ? sfa_pkg::TICK_REG_W'(1) : masked_ticks;
        o_cfg.speed    = r_speed_step;
        o_cfg.end_mode = r_end_mode;
    end

endmodule

`default_nettype wire

[hdl/sfa_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfa_core #(
    parameter int TICK_WIDTH = sfa_pkg::DEF_TICK_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic [sfa_pkg::OPCODE_W-1:0]    i_opcode,
    input  wire logic [sfa_pkg::FRAME_W-1:0]     i_target_frame,
    input  wire sfa_pkg::t_cfg                   i_cfg,
    output sfa_pkg::t_result                     o_result
);

    // The counter always stays below the tick period, so it needs only as
    // many bits as the period can have.
    localparam int CNT_W = (TICK_WIDTH < sfa_pkg::TICK_REG_W) ?
                           TICK_WIDTH : sfa_pkg::TICK_REG_W;

    logic [sfa_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [sfa_pkg::STATE_W-1:0] r_state, n_state;
    logic                        r_backward, n_backward;

    logic [sfa_pkg::SUM_W-1:0]   sum;
    logic [sfa_pkg::FRAME_W-1:0] frame_down;
    logic                        looped;
    logic                        done;
    logic                        rej;

    assign sum = sfa_pkg::SUM_W'(r_count) + sfa_pkg::SUM_W'(i_cfg.speed);
    assign frame_down = r_frame - sfa_pkg::FRAME_W'(1);

    // Next state for one command
    always_comb begin
        n_frame    = r_frame;
        n_count    = r_count;
        n_state    = r_state;
        n_backward = r_backward;
        looped     = 1'b0;
        done       = 1'b0;
        rej        = 1'b0;
        case (i_opcode)
            sfa_pkg::OP_TICK: begin
                if (r_state == sfa_pkg::ST_PLAYING) begin
                    if (sum >= sfa_pkg::SUM_W'(i_cfg.ticks)) begin
                        n_count = '0;
                        if (i_cfg.end_mode == sfa_pkg::MODE_PINGPONG && r_backward) begin
                            if (r_frame == '0) begin
                                // Bounce at the bottom turns forward again.
                                n_backward = 1'b0;
                                n_frame    = (i_cfg.num_frames > sfa_pkg::COUNT_W'(1)) ?
                                             sfa_pkg::FRAME_W'(1) : '0;
                                looped     = 1'b1;
                            end else if ({1'b0, frame_down} >= i_cfg.num_frames) begin
                                // Count shrank under us: land on the last frame.
                                n_frame = sfa_pkg::FRAME_W'(i_cfg.num_frames -
                                                            sfa_pkg::COUNT_W'(1));
                            end else begin
                                n_frame = frame_down;
                            end
                        end else if (sfa_pkg::COUNT_W'(r_frame) + sfa_pkg::COUNT_W'(1) >=
                                     i_cfg.num_frames) begin
                            if (i_cfg.end_mode == sfa_pkg::MODE_ONCE) begin
                                n_state = sfa_pkg::ST_STOPPED;
                                done    = 1'b1;
                            end else if (i_cfg.end_mode == sfa_pkg::MODE_PINGPONG) begin
                                n_backward = 1'b1;
                                n_frame    = (i_cfg.num_frames >= sfa_pkg::COUNT_W'(2)) ?
                                             sfa_pkg::FRAME_W'(i_cfg.num_frames -
                                                               sfa_pkg::COUNT_W'(2)) : '0;
                                looped     = 1'b1;
                            end else begin
                                n_frame = '0;
                                looped  = 1'b1;
                            end
                        end else begin
                            n_frame = r_frame + sfa_pkg::FRAME_W'(1);
                        end
                    end else begin
                        n_count = sum[CNT_W-1:0];
                    end
                end
            end
            sfa_pkg::OP_PLAY: begin
                if (r_state != sfa_pkg::ST_PLAYING) begin
                    n_state    = sfa_pkg::ST_PLAYING;
                    n_frame    = '0;
                    n_count    = '0;
                    n_backward = 1'b0;
                end
            end
            sfa_pkg::OP_STOP: begin
                n_state = sfa_pkg::ST_STOPPED;
                n_frame = '0;
                n_count = '0;
            end
            sfa_pkg::OP_PAUSE: begin
                if (r_state == sfa_pkg::ST_PLAYING) begin
                    n_state = sfa_pkg::ST_PAUSED;
                end
            end
            sfa_pkg::OP_RESUME: begin
                if (r_state == sfa_pkg::ST_PAUSED) begin
                    n_state = sfa_pkg::ST_PLAYING;
                end
            end
            sfa_pkg::OP_SET_FRAME: begin
                if (sfa_pkg::COUNT_W'(i_target_frame) < i_cfg.num_frames) begin
                    if (i_target_frame != r_frame) begin
                        n_frame = i_target_frame;
                        n_count = '0;
                    end
                end else begin
                    rej = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer state, updated once per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= '0;
            r_count    <= '0;
            r_state    <= sfa_pkg::ST_STOPPED;
            r_backward <= 1'b0;
        end else if (i_accept) begin
            r_frame    <= n_frame;
            r_count    <= n_count;
            r_state    <= n_state;
            r_backward <= n_backward;
        end
    end

    // Result for this command
    always_comb begin
        o_result.shown_frame   = n_frame;
        o_result.run_state     = n_state;
        o_result.frame_changed = (n_frame != r_frame);
        o_result.loop_complete = looped;
        o_result.anim_done     = done;
        o_result.rejected      = rej;
    end

endmodule

`default_nettype wire

[hdl/sprite_frame_animation_player.sv]
`timescale 1ns / 1ps
`default_nettype none

// Sprite frame animation player. Each input word is one command (tick, play,
// stop, pause, resume or set frame) and yields exactly one result word with
// the frame index and run state after the command, plus event flags. A
// command is taken every clock cycle while the result register is empty or
// being drained: the sequencer state and the result register both update
// in the cycle the word is accepted, so the result appears in the next
// cycle. Configuration writes take effect on the next command and should
// only be made while no result is pending.
module sprite_frame_animation_player #(
    parameter int MAX_FRAMES = sfa_pkg::DEF_MAX_FRAMES,
    parameter int TICK_WIDTH = sfa_pkg::DEF_TICK_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [sfa_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [sfa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // target_frame [7:0]
    input  wire logic [sfa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // opcode [2:0]
    input  wire logic [sfa_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // shown_frame [7:0], run_state [9:8], frame_changed [10],
    // loop_complete [11], anim_done [12], rejected [13], zero [15:14]
    output      logic [sfa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    sfa_pkg::t_cfg    cfg;
    sfa_pkg::t_result result;
    sfa_pkg::t_result r_result;
    logic             r_out_valid;
    logic             accept;

    sfa_cfg #(
        .MAX_FRAMES (MAX_FRAMES),
        .TICK_WIDTH (TICK_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input side is ready whenever the result register can take a new word.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sfa_core #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_opcode       (s_axis_tuser),
        .i_target_frame (s_axis_tdata),
        .i_cfg          (cfg),
        .o_result       (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_result};

endmodule

`default_nettype wire
